@@ src/bitmap_id_allocator_assert.svh @@
// assertion macros for the bitmap id allocator checker
// no dependencies; included by the checker file
`ifndef BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BIA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap id allocator port check failed");

// next-cycle implication
`define BIA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap id allocator port check failed");

`endif

@@ src/bia_pkg.sv @@
// shared types and constants of the bitmap id allocator
// no dependencies; imported by every module of the block
package bia_pkg;

   localparam int ID_COUNT_DEF = 1024;
   localparam int WORD_BITS    = 32;
   localparam int ID_W         = 16;

   // command codes
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_REL_RD,
      ST_REL_WR,
      ST_DONE
   } state_type;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id_out;
      logic [1:0]        status;
   } bia_result_type;

endpackage

@@ src/bia_flag_ram.sv @@
// word-wide store of used flags, one write and one registered read per cycle
// depends on bia_pkg for the word width
module bia_flag_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [AW-1:0]                  rd_addr,
   output logic [bia_pkg::WORD_BITS-1:0]  rd_data,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [bia_pkg::WORD_BITS-1:0]  wr_data
);
   import bia_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds its word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bia_scan_unit.sv @@
// lowest free bit finder over one flag word
// depends on bia_pkg for the word width
module bia_scan_unit (
   input  logic [bia_pkg::WORD_BITS-1:0] word_data,
   input  logic [bia_pkg::WORD_BITS-1:0] valid_mask,
   output logic                          found,
   output logic [4:0]                    pos
);
   import bia_pkg::*;

   logic [WORD_BITS-1:0] free_bits;
   logic [3:0]           byte_any;
   logic [1:0]           byte_sel;
   logic [7:0]           byte_bits;
   logic [2:0]           bit_sel;

   // a bit is free when clear and inside the id window
   assign free_bits = ~word_data & valid_mask;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         byte_any[k] = |free_bits[k*8 +: 8];
      end
   end

   // lowest byte holding a free bit
   always_comb begin
      byte_sel = 2'd0;
      for (int k = 3; k >= 0; k--) begin
         if (byte_any[k]) begin
            byte_sel = 2'(k);
         end
      end
   end

   assign byte_bits = free_bits[byte_sel*8 +: 8];

   // lowest free bit inside that byte
   always_comb begin
      bit_sel = 3'd0;
      for (int b = 7; b >= 0; b--) begin
         if (byte_bits[b]) begin
            bit_sel = 3'(b);
         end
      end
   end

   assign found = |byte_any;
   assign pos   = {byte_sel, bit_sel};

endmodule

@@ src/bia_seq.sv @@
// command sequencer: clear sweep, word scan for allocate, read-modify-write release
// depends on bia_pkg; drives bia_flag_ram and reads bia_scan_unit
module bia_seq #(
   parameter int ID_COUNT   = bia_pkg::ID_COUNT_DEF,
   parameter int WORD_COUNT = 32,
   parameter int AW         = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_command,
   input  logic [bia_pkg::ID_W-1:0]       req_id,
   input  logic                           cfg_we,
   input  logic [bia_pkg::ID_W-1:0]       cfg_data,
   input  logic                           out_free,
   output bia_pkg::bia_result_type        result,
   output logic                           rd_en,
   output logic [AW-1:0]                  rd_addr,
   input  logic [bia_pkg::WORD_BITS-1:0]  rd_data,
   output logic                           wr_en,
   output logic [AW-1:0]                  wr_addr,
   output logic [bia_pkg::WORD_BITS-1:0]  wr_data,
   output logic [bia_pkg::WORD_BITS-1:0]  scan_mask,
   input  logic                           scan_found,
   input  logic [4:0]                     scan_pos
);
   import bia_pkg::*;

   localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);
   localparam int            LAST_BITS = ID_COUNT - (WORD_COUNT - 1) * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

   state_type          state_ff, state_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [AW-1:0]      chk_addr_ff, chk_addr_in;
   logic [AW-1:0]      rel_addr_ff, rel_addr_in;
   logic [4:0]         rel_bit_ff, rel_bit_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [ID_W-1:0]    res_id_ff, res_id_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [ID_W-1:0]    base_id_ff;

   logic [ID_W-1:0]    rel_off;
   logic               in_range;
   logic [ID_W-1:0]    found_idx;

   // window test on the modular offset
   assign rel_off   = req_id - base_id_ff;
   assign in_range  = {1'b0, rel_off} < (ID_W + 1)'(ID_COUNT);
   assign found_idx = ID_W'({chk_addr_ff, scan_pos});
   assign scan_mask = (chk_addr_ff == LAST_ADDR) ? LAST_MASK : {WORD_BITS{1'b1}};

   assign req_ready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == LAST_ADDR) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_ALLOC:   state_in = ST_SCAN;
                  CMD_RELEASE: state_in = in_range ? ST_REL_RD : ST_DONE;
                  CMD_CLEAR:   state_in = ST_CLEAR;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff && (scan_found || (chk_addr_ff == LAST_ADDR))) begin
               state_in = ST_DONE;
            end
         end
         ST_REL_RD: state_in = ST_REL_WR;
         ST_REL_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // memory controls and datapath next values
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff;
      wr_data       = '0;
      cnt_in        = cnt_ff;
      chk_vld_in    = chk_vld_ff;
      chk_addr_in   = chk_addr_ff;
      rel_addr_in   = rel_addr_ff;
      rel_bit_in    = rel_bit_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cnt_in        = '0;
               chk_vld_in    = 1'b0;
               clr_rsp_in    = 1'b1;
               res_id_in     = '0;
               res_status_in = STATUS_DONE;
               rel_addr_in   = AW'(rel_off >> 5);
               rel_bit_in    = rel_off[4:0];
               if ((req_command == CMD_RELEASE) && !in_range) begin
                  res_status_in = STATUS_RANGE;
               end
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff && scan_found) begin
               // mark the lowest free bit used
               wr_en     = 1'b1;
               wr_addr   = chk_addr_ff;
               wr_data   = rd_data | (WORD_BITS'(1) << scan_pos);
               res_id_in = base_id_ff + found_idx;
            end else if (chk_vld_ff && (chk_addr_ff == LAST_ADDR)) begin
               res_status_in = STATUS_FULL;
            end else begin
               // fetch the next word while the current one is checked
               rd_en       = 1'b1;
               chk_addr_in = cnt_ff;
               chk_vld_in  = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end
         end
         ST_REL_RD: begin
            rd_en   = 1'b1;
            rd_addr = rel_addr_ff;
         end
         ST_REL_WR: begin
            wr_en   = 1'b1;
            wr_addr = rel_addr_ff;
            wr_data = rd_data & ~(WORD_BITS'(1) << rel_bit_ff);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         chk_vld_ff <= 1'b0;
         clr_rsp_ff <= 1'b0;
         base_id_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         chk_vld_ff <= chk_vld_in;
         clr_rsp_ff <= clr_rsp_in;
         if (cfg_we) begin
            base_id_ff <= cfg_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_addr_ff   <= chk_addr_in;
      rel_addr_ff   <= rel_addr_in;
      rel_bit_ff    <= rel_bit_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
   end

   assign result.valid  = (state_ff == ST_DONE);
   assign result.id_out = res_id_ff;
   assign result.status = res_status_ff;

endmodule

@@ src/bitmap_id_allocator.sv @@
// Bitmap id allocator: hands out the lowest free identifier from a used-flag map.
// Request channel (req_valid/req_ready) carries one word: req_command and req_id.
// Allocate returns base_id plus the lowest free index, or status full; release
// clears one flag or reports out of range; clear frees every id.
// Response channel (rsp_valid/rsp_ready) returns rsp_id_out and rsp_status.
// Configuration channel csr_valid/csr_ready writes base_id; write it while idle.
// Flags live in a RAM of 32-bit words with one registered read port, and the
// allocate scan reads one word per cycle and stops at the first word with a
// free bit or after the last word; release reads its flag word and writes it
// back, and clear sweeps every word to zero.
// One request is worked on at a time; req_ready is high only while idle.
// After reset the block sweeps the RAM to zero, one word a cycle, and holds
// req_ready low meanwhile; csr writes are taken at any time.
// A result waits in the output register while the receiver stalls, and the next
// request may be taken meanwhile; its result waits in turn until that slot frees.
module bitmap_id_allocator #(
   parameter int ID_COUNT = bia_pkg::ID_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [bia_pkg::ID_W-1:0]  req_id,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [bia_pkg::ID_W-1:0]  rsp_id_out,
   output logic [1:0]                rsp_status,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bia_pkg::ID_W-1:0]  csr_base_id
);
   import bia_pkg::*;

   localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [WORD_BITS-1:0]  rd_data, wr_data, scan_mask;
   logic                  scan_found;
   logic [4:0]            scan_pos;
   logic                  out_free;
   bia_result_type        result;

   logic                  rsp_valid_ff;
   logic [ID_W-1:0]       rsp_id_out_ff;
   logic [1:0]            rsp_status_ff;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   bia_flag_ram #(
      .DEPTH (WORD_COUNT),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bia_scan_unit u_scan (
      .word_data  (rd_data),
      .valid_mask (scan_mask),
      .found      (scan_found),
      .pos        (scan_pos)
   );

   bia_seq #(
      .ID_COUNT   (ID_COUNT),
      .WORD_COUNT (WORD_COUNT),
      .AW         (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_id      (req_id),
      .cfg_we      (csr_valid),
      .cfg_data    (csr_base_id),
      .out_free    (out_free),
      .result      (result),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .scan_mask   (scan_mask),
      .scan_found  (scan_found),
      .scan_pos    (scan_pos)
   );

   // output register, parts the sequencer from a stalling receiver
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid && out_free) begin
         rsp_id_out_ff <= result.id_out;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_id_out = rsp_id_out_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ src/bia_checker.sv @@
// port-level checks of the bitmap id allocator, bound to the top level
// depends on bia_pkg and bitmap_id_allocator_assert.svh
`include "bitmap_id_allocator_assert.svh"

module bia_port_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [bia_pkg::ID_W-1:0]  req_id,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [bia_pkg::ID_W-1:0]  rsp_id_out,
   input  logic [1:0]                rsp_status,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [bia_pkg::ID_W-1:0]  csr_base_id
);
   import bia_pkg::*;

   logic [ID_W+1:0] rsp_word;

   // response payload as one vector
   assign rsp_word = {rsp_id_out, rsp_status};

   // a taken word leaves the block busy in the next cycle
   `BIA_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

   // a stalled response holds
   `BIA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // a failed command returns no id
   `BIA_ASSERT_IMP(a_fail_no_id, clock, reset, rsp_valid && (rsp_status != STATUS_DONE), rsp_id_out == '0)

   // a fresh response only comes out of a busy cycle
   `BIA_ASSERT_IMP(a_rsp_after_busy, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind bitmap_id_allocator bia_port_checker u_bia_checker (.*);

@@ test/bia_checker.sv @@
`timescale 1ns / 1ps
// scoreboard of the bitmap id allocator: watches the request, response and csr channels,
// keeps its own used-flag map and base id, and checks each response word in order
// depends on bia_pkg
module bia_checker #(
   parameter int ID_COUNT = bia_pkg::ID_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_command,
   input  logic [bia_pkg::ID_W-1:0] req_id,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [bia_pkg::ID_W-1:0] rsp_id_out,
   input  logic [1:0]               rsp_status,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [bia_pkg::ID_W-1:0] csr_base_id,
   output int                       error_count,
   output int                       pending_count,
   output int                       checked_count,
   output int                       full_count,
   output int                       range_count
);
   import bia_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0] id_out;
      logic [1:0]      status;
   } answer_type;

   logic            used_map [ID_COUNT];
   logic [ID_W-1:0] base_reg;
   answer_type      answer_queue [$];
   int              errors;
   int              checked;
   int              fulls;
   int              ranges;

   // apply one request word to the flag map and work out its response word
   function automatic answer_type serve_request(logic [1:0] cmd, logic [ID_W-1:0] id);
      answer_type      ans;
      logic [ID_W-1:0] offset;
      logic            found;
      ans.id_out = '0;
      ans.status = STATUS_DONE;
      found      = 1'b0;
      case (cmd)
         CMD_ALLOC: begin
            // lowest free index wins
            for (int i = 0; i < ID_COUNT && !found; i++) begin
               if (!used_map[i]) begin
                  used_map[i] = 1'b1;
                  ans.id_out  = base_reg + ID_W'(i);
                  found       = 1'b1;
               end
            end
            if (!found) begin
               ans.status = STATUS_FULL;
            end
         end
         CMD_RELEASE: begin
            // modular offset, so wrapped ids still hit their flag
            offset = id - base_reg;
            if (offset < ID_COUNT) begin
               used_map[offset] = 1'b0;
            end else begin
               ans.status = STATUS_RANGE;
            end
         end
         CMD_CLEAR: begin
            foreach (used_map[k]) used_map[k] = 1'b0;
         end
         default: begin
            // spare code leaves the map alone
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         foreach (used_map[k]) used_map[k] = 1'b0;
         base_reg = '0;
         answer_queue.delete();
         errors  = 0;
         checked = 0;
         fulls   = 0;
         ranges  = 0;
      end else begin
         // response side: oldest expectation first
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (rsp_status === STATUS_FULL) fulls++;
            if (rsp_status === STATUS_RANGE) ranges++;
            if (answer_queue.size() == 0) begin
               $display("%0t: response word with nothing expected, id_out %h status %0d",
                        $time, rsp_id_out, rsp_status);
               errors++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_id_out !== want.id_out) begin
                  $display("%0t: id_out mismatch, expected %h actual %h",
                           $time, want.id_out, rsp_id_out);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
            end
         end
         // base id register
         if (csr_valid && csr_ready) begin
            base_reg = csr_base_id;
         end
         // request side
         if (req_valid && req_ready) begin
            answer_queue.push_back(serve_request(req_command, req_id));
         end
      end
      error_count   <= errors;
      pending_count <= answer_queue.size();
      checked_count <= checked;
      full_count    <= fulls;
      range_count   <= ranges;
   end

endmodule

@@ test/tb_bitmap_id_allocator.sv @@
`timescale 1ns / 1ps
// top of the bitmap id allocator testbench: clock, reset, stimulus phases and verdict
// depends on bia_pkg, bitmap_id_allocator and bia_checker
module tb_bitmap_id_allocator;
   import bia_pkg::*;

   localparam logic [1:0] CMD_SPARE   = 2'd3;
   localparam int         HOLD_CYCLES = 400;
   localparam int         QUIET_LIMIT = 3000;
   localparam int         DRAIN_WAIT  = 40;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [1:0]      req_command;
   logic [ID_W-1:0] req_id;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [ID_W-1:0] rsp_id_out;
   logic [1:0]      rsp_status;
   logic            csr_valid;
   logic            csr_ready;
   logic [ID_W-1:0] csr_base_id;

   int              error_count;
   int              pending_count;
   int              checked_count;
   int              full_count;
   int              range_count;

   int              sender_idle_pct;
   int              stall_pct;
   logic            pressure_req;
   logic            pressure_done;
   logic [ID_W-1:0] base_now;
   int              sent_count;
   int              quiet_cycles;

   bitmap_id_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_id      (req_id),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_id_out  (rsp_id_out),
      .rsp_status  (rsp_status),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_base_id (csr_base_id)
   );

   bia_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_id        (req_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_id_out    (rsp_id_out),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_base_id   (csr_base_id),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .full_count    (full_count),
      .range_count   (range_count)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready     = 1'b0;
      pressure_done = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_req && !pressure_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            pressure_done = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   // offer one request word; returns at the falling edge after it was taken,
   // with valid still high so that a following word keeps it up
   task automatic send_word(input logic [1:0] cmd, input logic [ID_W-1:0] id);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_command = cmd;
      req_id      = id;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count++;
   endtask

   // stop offering and wait until every response word is back
   task automatic drain_requests();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_base(input logic [ID_W-1:0] value);
      csr_valid   = 1'b1;
      csr_base_id = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      base_now  = value;
   endtask

   // mostly allocations, some releases around the window, rare spare codes;
   // clear only from word clear_from on
   task automatic random_run(input int count, input int clear_pct, input int clear_from);
      int              roll;
      logic [1:0]      cmd;
      logic [ID_W-1:0] id;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(999);
         id   = ID_W'($urandom_range(65535));
         if (n >= clear_from && $urandom_range(99) < clear_pct) begin
            cmd = CMD_CLEAR;
         end else if (roll < 920) begin
            cmd = CMD_ALLOC;
         end else if (roll < 970) begin
            cmd = CMD_RELEASE;
            if ($urandom_range(1) == 0) begin
               id = base_now + ID_W'($urandom_range(63));
            end else begin
               id = base_now + ID_W'($urandom_range(1023));
            end
         end else if (roll < 985) begin
            cmd = CMD_SPARE;
         end else begin
            // window edges and stray ids
            cmd = CMD_RELEASE;
            case ($urandom_range(2))
               0: id = base_now - 16'd1;
               1: id = base_now + 16'd1024;
               default: id = ID_W'($urandom_range(65535));
            endcase
         end
         send_word(cmd, id);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = CMD_ALLOC;
      req_id          = '0;
      csr_valid       = 1'b0;
      csr_base_id     = '0;
      pressure_req    = 1'b0;
      sender_idle_pct = 0;
      stall_pct       = 0;
      base_now        = '0;
      sent_count      = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: base zero, reuse of the lowest free slot, window edges
      write_base(16'h0000);
      send_word(CMD_RELEASE, 16'd5);
      send_word(CMD_ALLOC, 16'hFFFF);
      send_word(CMD_ALLOC, 16'h0000);
      send_word(CMD_ALLOC, 16'h5555);
      send_word(CMD_RELEASE, 16'd1);
      send_word(CMD_ALLOC, 16'hAAAA);
      send_word(CMD_RELEASE, 16'd1023);
      send_word(CMD_RELEASE, 16'd1024);
      send_word(CMD_RELEASE, 16'hFFFF);
      send_word(CMD_SPARE, 16'hFFFF);
      send_word(CMD_CLEAR, 16'hAAAA);
      send_word(CMD_ALLOC, 16'h0000);

      // directed: highest regular base
      drain_requests();
      write_base(16'hFC00);
      send_word(CMD_ALLOC, 16'h0000);
      send_word(CMD_RELEASE, 16'hFFFF);
      send_word(CMD_RELEASE, 16'hFBFF);
      send_word(CMD_RELEASE, 16'h0000);

      // directed: base that wraps past 65535
      drain_requests();
      write_base(16'hFFFF);
      send_word(CMD_ALLOC, 16'h0000);
      send_word(CMD_RELEASE, 16'h0001);
      send_word(CMD_RELEASE, 16'hFFFF);
      send_word(CMD_RELEASE, 16'h03FE);
      send_word(CMD_RELEASE, 16'h03FF);
      send_word(CMD_SPARE, 16'h0000);
      send_word(CMD_CLEAR, 16'hFFFF);

      // random phase, no idling
      drain_requests();
      write_base(16'h0000);
      random_run(450, 0, 0);

      // sender idle most of the time
      drain_requests();
      sender_idle_pct = 64;
      write_base(16'hFC00);
      random_run(300, 0, 0);

      // receiver stalling most of the time
      drain_requests();
      sender_idle_pct = 0;
      stall_pct       = 64;
      write_base(16'hFFFF);
      random_run(300, 0, 0);

      // long receiver hold-off while words keep coming
      drain_requests();
      stall_pct    = 0;
      write_base(ID_W'($urandom_range(65535)));
      pressure_req = 1'b1;
      random_run(40, 0, 0);

      // light idling on both sides, map runs full, clears near the end
      drain_requests();
      sender_idle_pct = 12;
      stall_pct       = 12;
      write_base(ID_W'($urandom_range(65535)));
      random_run(460, 3, 340);

      drain_requests();
      repeat (DRAIN_WAIT) @(negedge clock);
      $display("run covered %0d request words: directed part and five random phases,",
               sent_count);
      $display("base ids 0, 64512, 65535 and random; %0d responses, %0d full, %0d out of range",
               checked_count, full_count, range_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
